FILE: rtl/nine_bit_packet_deframer_assert.svh
// ---------------------------------------------------------------------------
// Nine-bit packet deframer assertion macros
// Shared concurrent assertion forms, sampled on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef NINE_BIT_PACKET_DEFRAMER_ASSERT_SVH
`define NINE_BIT_PACKET_DEFRAMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NPD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`endif

FILE: rtl/npd_pkg.sv
// ---------------------------------------------------------------------------
// Nine-bit packet deframer package
// Phase and event codes, and the state and result records of the deframer.
// ---------------------------------------------------------------------------
package npd_pkg;

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_ADDR_LO = 3'd1;
   localparam logic [2:0] PH_LEN_HI  = 3'd2;
   localparam logic [2:0] PH_LEN_LO  = 3'd3;
   localparam logic [2:0] PH_DATA    = 3'd4;
   localparam logic [2:0] PH_CRC_HI  = 3'd5;
   localparam logic [2:0] PH_CRC_LO  = 3'd6;

   localparam logic [1:0] EV_DATA  = 2'd0;
   localparam logic [1:0] EV_DONE  = 2'd1;
   localparam logic [1:0] EV_ABORT = 2'd2;

   typedef struct packed {
      logic        mark_flag;
      logic [7:0]  rx_byte;
   } npd_item_type;

   typedef struct packed {
      logic [2:0]  phase;
      logic [7:0]  address_high;
      logic [15:0] length_count;
      logic [15:0] bytes_seen;
      logic [7:0]  crc_high;
   } npd_state_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
      logic [15:0] frame_length;
      logic [15:0] received_crc;
   } npd_result_type;

endpackage

FILE: rtl/npd_channels.sv
// ---------------------------------------------------------------------------
// Nine-bit packet deframer channels
// Valid/ready channels for received characters and for deframer results.
// ---------------------------------------------------------------------------
interface npd_req_if;
   logic       valid;
   logic       ready;
   logic       mark_flag;
   logic [7:0] rx_byte;

   modport source (output valid, output mark_flag, output rx_byte, input ready);
   modport sink (input valid, input mark_flag, input rx_byte, output ready);
endinterface

interface npd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [7:0]  data_byte;
   logic [15:0] byte_index;
   logic [15:0] frame_length;
   logic [15:0] received_crc;

   modport source (output valid, output event_kind, output data_byte, output byte_index,
                   output frame_length, output received_crc, input ready);
   modport sink (input valid, input event_kind, input data_byte, input byte_index,
                 input frame_length, input received_crc, output ready);
endinterface

FILE: rtl/nine_bit_packet_deframer.sv
// ---------------------------------------------------------------------------
// Nine-bit packet deframer
// An accepted character is held in the input register, and its result in the result register, before it is on rsp.
// Throughput: one character per cycle while rsp takes results; the phase update is one register step.
// Reset clears the phase to hunting, the counters, both valids and own_address.
// ---------------------------------------------------------------------------
`include "nine_bit_packet_deframer_assert.svh"

module nine_bit_packet_deframer
   import npd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   npd_req_if.sink       req_ch,
   npd_rsp_if.source     rsp_ch,
   input  logic          csr_write_en,
   input  logic [15:0]   csr_write_data
);

   logic           in_valid_ff, in_valid_in;
   npd_item_type   in_item_ff, in_item_in;
   npd_state_type  state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   npd_result_type rsp_data_ff, rsp_data_in;
   logic [15:0]    own_address_ff, own_address_in;

   npd_state_type  state_nxt;
   logic           result_valid;
   npd_result_type result;
   logic           advance;
   logic           req_take;

   npd_core u_core (
      .state_cur    (state_ff),
      .item         (in_item_ff),
      .own_address  (own_address_ff),
      .state_nxt    (state_nxt),
      .result_valid (result_valid),
      .result       (result)
   );

   // The input register moves on whenever the result register can take its outcome.
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in    = req_ch.ready ? req_ch.valid : in_valid_ff;
      in_item_in     = req_take ? {req_ch.mark_flag, req_ch.rx_byte} : in_item_ff;
      state_in       = (advance && in_valid_ff) ? state_nxt : state_ff;
      rsp_valid_in   = advance ? (in_valid_ff && result_valid) : rsp_valid_ff;
      rsp_data_in    = (advance && in_valid_ff) ? result : rsp_data_ff;
      own_address_in = csr_write_en ? csr_write_data : own_address_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         state_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         own_address_ff <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         own_address_ff <= own_address_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.event_kind   = rsp_data_ff.event_kind;
   assign rsp_ch.data_byte    = rsp_data_ff.data_byte;
   assign rsp_ch.byte_index   = rsp_data_ff.byte_index;
   assign rsp_ch.frame_length = rsp_data_ff.frame_length;
   assign rsp_ch.received_crc = rsp_data_ff.received_crc;

   `NPD_ASSERT_SAME(a_data_index_in_range,
      rsp_valid_ff && (rsp_data_ff.event_kind == EV_DATA),
      rsp_data_ff.byte_index < rsp_data_ff.frame_length)
   `NPD_ASSERT_SAME(a_done_index_is_length,
      rsp_valid_ff && (rsp_data_ff.event_kind == EV_DONE),
      rsp_data_ff.byte_index == rsp_data_ff.frame_length)
   `NPD_ASSERT_SAME(a_payload_count_below_length,
      state_ff.phase == PH_DATA,
      state_ff.bytes_seen < state_ff.length_count)
   `NPD_ASSERT_NEXT(a_stalled_item_held,
      in_valid_ff && !advance,
      in_valid_ff && $stable(in_item_ff))
   `NPD_ASSERT_NEXT(a_abort_resumes_hunt,
      in_valid_ff && advance && result_valid && (result.event_kind == EV_ABORT),
      state_ff.phase == PH_HUNT)

endmodule

FILE: rtl/npd_core.sv
// ---------------------------------------------------------------------------
// Nine-bit packet deframer phase logic
// Next state and optional result for one received character.
// ---------------------------------------------------------------------------
module npd_core
   import npd_pkg::*;
(
   input  npd_state_type  state_cur,
   input  npd_item_type   item,
   input  logic [15:0]    own_address,
   output npd_state_type  state_nxt,
   output logic           result_valid,
   output npd_result_type result
);

   logic        mark;
   logic [7:0]  b;
   logic [15:0] seen_inc;
   logic [15:0] length_new;

   assign mark       = item.mark_flag;
   assign b          = item.rx_byte;
   assign seen_inc   = state_cur.bytes_seen + 16'd1;
   assign length_new = {state_cur.length_count[15:8], b};

   always_comb begin
      state_nxt    = state_cur;
      result_valid = 1'b0;
      result       = '0;
      // Once the address matched, a marked character aborts the frame.
      if (mark && (state_cur.phase inside {[PH_LEN_HI:PH_CRC_LO]})) begin
         result_valid      = 1'b1;
         result.event_kind = EV_ABORT;
         if (state_cur.phase inside {[PH_DATA:PH_CRC_LO]}) begin
            result.byte_index   = state_cur.bytes_seen;
            result.frame_length = state_cur.length_count;
         end
         state_nxt.phase = PH_HUNT;
      end else begin
         case (state_cur.phase)
            PH_ADDR_LO: begin
               if (mark && ({state_cur.address_high, b} == own_address)) begin
                  state_nxt.phase = PH_LEN_HI;
               end else begin
                  state_nxt.phase = PH_HUNT;
               end
            end
            PH_LEN_HI: begin
               state_nxt.length_count = {b, 8'h00};
               state_nxt.phase        = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               state_nxt.length_count = length_new;
               state_nxt.bytes_seen   = '0;
               state_nxt.phase        = (length_new == 16'd0) ? PH_CRC_HI : PH_DATA;
            end
            PH_DATA: begin
               result_valid         = 1'b1;
               result.event_kind    = EV_DATA;
               result.data_byte     = b;
               result.byte_index    = state_cur.bytes_seen;
               result.frame_length  = state_cur.length_count;
               state_nxt.bytes_seen = seen_inc;
               if (seen_inc == state_cur.length_count) begin
                  state_nxt.phase = PH_CRC_HI;
               end
            end
            PH_CRC_HI: begin
               state_nxt.crc_high = b;
               state_nxt.phase    = PH_CRC_LO;
            end
            PH_CRC_LO: begin
               result_valid        = 1'b1;
               result.event_kind   = EV_DONE;
               result.byte_index   = state_cur.length_count;
               result.frame_length = state_cur.length_count;
               result.received_crc = {state_cur.crc_high, b};
               state_nxt.phase     = PH_HUNT;
            end
            default: begin
               // Hunting, and the unused phase code, look for the address high byte.
               if (mark) begin
                  state_nxt.address_high = b;
                  state_nxt.phase        = PH_ADDR_LO;
               end else begin
                  state_nxt.phase = PH_HUNT;
               end
            end
         endcase
      end
   end

endmodule
